@@ src/sms_pkg.sv @@
// shared constants and types for the sliding median spike detector
// no dependencies; imported by every module of the block
package sms_pkg;

	localparam int MAX_WINDOW  = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int LEN_BITS    = $clog2(MAX_WINDOW + 1);
	localparam int IDX_BITS    = $clog2(MAX_WINDOW);
	localparam int REF_BITS    = SAMPLE_BITS + 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [LEN_BITS-1:0]    len_t;
	typedef logic [IDX_BITS-1:0]    idx_t;
	typedef logic [COUNT_BITS-1:0]  count_t;

	// broadcast to every cell of the sorted chain
	typedef struct packed {
		logic    ins;      // window filling: insert only
		sample_t x;        // new sample
		sample_t o;        // oldest sample leaving the window
	} cell_ctl_t;

endpackage

@@ src/sliding_median_spike_detector.sv @@
// a result is registered in ST_UPD after its beat is taken, once the output is free
// one beat at a time: taking a beat reads the oldest sample from the history ring
// and the median from the cell chain; ST_UPD then shifts the cells below lim in place
// a new beat is taken while the previous result still waits in the output register
// reset clears fill level, ring pointer, alert count, output valid; window length goes to 1
// sorted cells and history ring are not cleared, only filled slots are ever used
module sliding_median_spike_detector (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  sms_pkg::len_t          cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sms_pkg::sample_t       amount,
	input  logic                   restart,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   alert,
	output sms_pkg::count_t        alert_count,
	output logic                   window_full
);
	import sms_pkg::*;

	typedef enum logic {ST_IDLE, ST_UPD} state_t;

	state_t    state_q;
	len_t      wlen_q;
	len_t      fill_q;
	idx_t      oldest_q;
	count_t    total_q;
	logic      out_valid_q;
	logic      alert_q;
	count_t    count_q;
	logic      full_q;

	sample_t   x_s1;
	logic      full_s1;
	len_t      fill_s1;
	logic [REF_BITS-1:0] ref_s1;
	sample_t   ring_rd_s1;

	sample_t   ring_q [MAX_WINDOW];
	sample_t   cell_v [MAX_WINDOW];

	len_t      wl_eff;
	len_t      fill_eff;
	logic      full_now;
	idx_t      slot;
	len_t      slot_inc;
	idx_t      wr_addr;
	idx_t      mid;
	logic [REF_BITS-1:0] ref_now;
	logic      accept;
	logic      done;
	logic      alert_now;
	count_t    total_nxt;
	len_t      lim;
	cell_ctl_t ctl;

	always_comb begin
		if (wlen_q == '0) begin
			wl_eff = len_t'(1);
		end else if (wlen_q > len_t'(MAX_WINDOW)) begin
			wl_eff = len_t'(MAX_WINDOW);
		end else begin
			wl_eff = wlen_q;
		end
	end

	assign accept   = in_valid && in_ready;
	assign fill_eff = restart ? '0 : fill_q;
	assign full_now = fill_eff >= wl_eff;
	assign slot     = (len_t'(oldest_q) < wl_eff) ? oldest_q : '0;
	assign slot_inc = len_t'(slot) + len_t'(1);
	assign wr_addr  = full_now ? slot : fill_eff[IDX_BITS-1:0];

	// median taps: upper middle and lower middle of the sorted chain
	assign mid = wl_eff[LEN_BITS-1:1];
	always_comb begin
		if (wl_eff[0]) begin
			ref_now = {cell_v[mid], 1'b0};
		end else begin
			ref_now = {1'b0, cell_v[mid - idx_t'(1)]} + {1'b0, cell_v[mid]};
		end
	end

	assign done      = (state_q == ST_UPD) && (!out_valid_q || out_ready);
	assign alert_now = full_s1 && ({1'b0, x_s1} >= ref_s1);
	assign total_nxt = (alert_now && total_q != COUNT_MAX) ? total_q + count_t'(1) : total_q;

	// cells below lim take part in the shift
	assign lim     = full_s1 ? wl_eff : fill_s1 + len_t'(1);
	assign ctl.ins = !full_s1;
	assign ctl.x   = x_s1;
	assign ctl.o   = ring_rd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wlen_q      <= len_t'(1);
			fill_q      <= '0;
			oldest_q    <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			alert_q     <= 1'b0;
			count_q     <= '0;
			full_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !done) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_wen) begin
						wlen_q   <= cfg_wdata;
						fill_q   <= '0;
						oldest_q <= '0;
					end else if (accept) begin
						if (restart) begin
							total_q <= '0;
						end
						if (full_now) begin
							fill_q   <= fill_eff;
							oldest_q <= (slot_inc >= wl_eff) ? '0 : slot_inc[IDX_BITS-1:0];
						end else begin
							fill_q   <= fill_eff + len_t'(1);
							oldest_q <= '0;
						end
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (done) begin
						total_q     <= total_nxt;
						out_valid_q <= 1'b1;
						alert_q     <= alert_now;
						count_q     <= total_nxt;
						full_q      <= full_s1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= amount;
			full_s1 <= full_now;
			fill_s1 <= fill_eff;
			ref_s1  <= ref_now;
		end
	end

	// history ring: read of the leaving sample sees the value before this write
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q[wr_addr] <= amount;
			ring_rd_s1      <= ring_q[slot];
		end
	end

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		sms_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.we      (done && (len_t'(i) < lim)),
			.nxt_ok  (len_t'(i + 1) < lim),
			.left_ok (i > 0),
			.left_v  (cell_v[(i > 0) ? i - 1 : 0]),
			.right_v (cell_v[(i < MAX_WINDOW - 1) ? i + 1 : i]),
			.val     (cell_v[i])
		);
	end

	// no beat while the window length is being written
	assign in_ready    = (state_q == ST_IDLE) && !cfg_wen;
	assign out_valid   = out_valid_q;
	assign alert       = alert_q;
	assign alert_count = count_q;
	assign window_full = full_q;

endmodule

@@ src/sms_cell.sv @@
// one slot of the sorted chain: holds a sample, on update takes a neighbor's value or x
// depends on sms_pkg
module sms_cell (
	input  logic              clk,
	input  sms_pkg::cell_ctl_t ctl,
	input  logic              we,
	input  logic              nxt_ok,
	input  logic              left_ok,
	input  sms_pkg::sample_t  left_v,
	input  sms_pkg::sample_t  right_v,
	output sms_pkg::sample_t  val
);
	import sms_pkg::*;

	sample_t val_q;
	sample_t val_nxt;

	always_comb begin
		val_nxt = val_q;
		if (ctl.ins) begin
			// keep if occupied and not above x, else shift right or take x
			if (nxt_ok && val_q <= ctl.x) begin
				val_nxt = val_q;
			end else if (left_ok && left_v > ctl.x) begin
				val_nxt = left_v;
			end else begin
				val_nxt = ctl.x;
			end
		end else if (ctl.x >= ctl.o) begin
			// span from the removed slot up to x moves left
			if (val_q >= ctl.o) begin
				if (nxt_ok && right_v < ctl.x) begin
					val_nxt = right_v;
				end else if (val_q <= ctl.x) begin
					val_nxt = ctl.x;
				end
			end
		end else begin
			// span from x up to the removed slot moves right
			if (val_q <= ctl.o) begin
				if (left_ok && left_v > ctl.x) begin
					val_nxt = left_v;
				end else if (val_q >= ctl.x) begin
					val_nxt = ctl.x;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			val_q <= val_nxt;
		end
	end

	assign val = val_q;

endmodule

@@ src/sms_checker.sv @@
// port-level checks for the sliding median spike detector
// depends on sms_pkg; bound to sliding_median_spike_detector below
module sms_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input sms_pkg::sample_t      amount,
	input logic                  restart,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic                  alert,
	input sms_pkg::count_t       alert_count,
	input logic                  window_full
);
	import sms_pkg::*;

	// one beat at a time: the block is busy the cycle after taking a beat
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on back to back cycles");

	// an alert needs a full window
	a_alert_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alert |-> window_full)
		else $error("alert without a full window");

	// a new result only follows a cycle of work
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an update cycle");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(alert_count) && $stable(alert))
		else $error("stalled result changed");

	// waiting input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(amount) && $stable(restart))
		else $error("waiting input beat changed");

endmodule

bind sliding_median_spike_detector sms_checker u_sms_checker (.*);

@@ tb/tb_sliding_median_spike_detector.sv @@
// testbench for sliding_median_spike_detector: directed and random samples over many window lengths
// depends on sms_pkg and the block; predicts alert, alert count and window-full per sample
// valid/ready driver and monitor with random idle on both sides, results compared in order
module tb_sliding_median_spike_detector;
	timeunit 1ns;
	timeprecision 1ps;
	import sms_pkg::*;

	typedef struct {
		sample_t amount;
		logic    restart;
	} sample_beat_t;

	typedef struct packed {
		logic   alert;
		count_t count;
		logic   full;
	} verdict_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cfg_wen = 1'b0;
	len_t    cfg_wdata = '0;
	logic    in_valid = 1'b0;
	logic    in_ready;
	sample_t amount = '0;
	logic    restart = 1'b0;
	logic    out_valid;
	logic    out_ready = 1'b0;
	logic    alert;
	count_t  alert_count;
	logic    window_full;

	sliding_median_spike_detector DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.amount      (amount),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.alert       (alert),
		.alert_count (alert_count),
		.window_full (window_full)
	);

	always #1 clk = ~clk;

	// predicted block state
	sample_t     sorted_win [MAX_WINDOW];
	sample_t     arrival_ring [MAX_WINDOW];
	len_t        win_len = len_t'(1);
	int unsigned held = 0;
	int unsigned oldest = 0;
	count_t      alert_total = '0;

	sample_beat_t samples_to_send [$];
	verdict_t     verdicts_due [$];
	verdict_t     want_v;
	bit           quiet = 1'b0;
	int unsigned  gap_left = 0;
	int unsigned  stall_left = 0;
	int unsigned  errors = 0;
	int unsigned  checked = 0;
	int unsigned  judged = 0;
	int unsigned  alerts_seen = 0;
	int unsigned  settings_run = 0;
	int unsigned  random_sent = 0;

	function automatic int unsigned live_window();
		if (win_len == 0) return 1;
		if (win_len > MAX_WINDOW) return MAX_WINDOW;
		return 32'(win_len);
	endfunction

	function automatic int unsigned first_at_least(int unsigned n, sample_t v);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (sorted_win[mid] < v) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	function automatic void sorted_put(int unsigned n, sample_t v);
		int unsigned pos;
		pos = first_at_least(n, v);
		for (int unsigned i = n; i > pos; i--) sorted_win[i] = sorted_win[i-1];
		sorted_win[pos] = v;
	endfunction

	function automatic void sorted_drop(int unsigned n, sample_t v);
		int unsigned pos;
		pos = first_at_least(n, v);
		if (pos < n) begin
			for (int unsigned i = pos; i + 1 < n; i++) sorted_win[i] = sorted_win[i+1];
		end
	endfunction

	function automatic verdict_t judge_sample(sample_t a, logic rs);
		verdict_t    vd;
		int unsigned w, slot;
		logic [SAMPLE_BITS:0] thresh;
		w = live_window();
		vd = '0;
		if (rs) begin
			held = 0;
			oldest = 0;
			alert_total = '0;
		end
		if (held < w) begin
			sorted_put(held, a);
			arrival_ring[held] = a;
			held++;
			oldest = 0;
		end else begin
			slot = (oldest < w) ? oldest : 0;
			vd.full = 1'b1;
			// even window: sum of both middles stands in for twice the median
			if (w % 2 == 0)
				thresh = {1'b0, sorted_win[w/2-1]} + {1'b0, sorted_win[w/2]};
			else
				thresh = {sorted_win[w/2], 1'b0};
			if ({1'b0, a} >= thresh) begin
				vd.alert = 1'b1;
				if (alert_total != COUNT_MAX) alert_total++;
			end
			sorted_drop(w, arrival_ring[slot]);
			sorted_put(w - 1, a);
			arrival_ring[slot] = a;
			slot++;
			oldest = (slot >= w) ? 0 : slot;
		end
		vd.count = alert_total;
		return vd;
	endfunction

	// mostly short idles, a few long ones
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic sample_t pick_amount(int unsigned style);
		int unsigned r;
		r = $urandom_range(0, 99);
		case (style)
			0: begin
				if (r < 85) return sample_t'($urandom_range(200, 1200));
				return sample_t'($urandom_range(2400, 65535));
			end
			1: return sample_t'($urandom_range(0, 7));
			2: begin
				if (r < 10) return '0;
				if (r < 20) return '1;
				return sample_t'($urandom_range(0, 65535));
			end
			default: begin
				// exact ties with twice a median of 100
				if (r < 60) return sample_t'(100);
				if (r < 75) return sample_t'(199);
				if (r < 90) return sample_t'(200);
				return sample_t'(201);
			end
		endcase
	endfunction

	// driver: one beat held until accepted, then an optional gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready)
				verdicts_due.insert(verdicts_due.size(), judge_sample(amount, restart));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (samples_to_send.size() > 0) begin
					in_valid <= 1'b1;
					amount <= samples_to_send[0].amount;
					restart <= samples_to_send[0].restart;
					void'(samples_to_send.pop_front());
					gap_left = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, in-order compare
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (verdicts_due.size() == 0) begin
					$error("result beat with no expected result waiting");
					errors++;
				end else begin
					want_v = verdicts_due.pop_front();
					checked++;
					if (window_full) judged++;
					if (alert) alerts_seen++;
					if (alert !== want_v.alert) begin
						$error("alert: expected %0d, got %0d", want_v.alert, alert);
						errors++;
					end
					if (alert_count !== want_v.count) begin
						$error("alert_count: expected %0d, got %0d", want_v.count, alert_count);
						errors++;
					end
					if (window_full !== want_v.full) begin
						$error("window_full: expected %0d, got %0d", want_v.full, window_full);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				stall_left = idle_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		do @(negedge clk);
		while (samples_to_send.size() != 0 || in_valid || verdicts_due.size() != 0);
	endtask

	task automatic send(sample_t a, logic rs);
		sample_beat_t b;
		b.amount = a;
		b.restart = rs;
		samples_to_send.insert(samples_to_send.size(), b);
	endtask

	task automatic set_window(int unsigned len_val);
		wait_drained();
		repeat (6) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= len_t'(len_val);
		@(posedge clk);
		cfg_wen <= 1'b0;
		// a length write empties the window but keeps the alert count
		win_len = len_t'(len_val);
		held = 0;
		oldest = 0;
		settings_run++;
		@(negedge clk);
	endtask

	task automatic random_phase(int unsigned len_val, int unsigned n_items);
		int unsigned style;
		set_window(len_val);
		style = $urandom_range(0, 3);
		quiet = ($urandom_range(0, 4) == 0);
		repeat (n_items) begin
			send(pick_amount(style), $urandom_range(0, 79) == 0);
			random_sent++;
			// sender holds off until the block has nothing outstanding
			if ($urandom_range(0, 149) == 0) wait_drained();
		end
	endtask

	initial begin
		int unsigned r, len_pick;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset length of one: zero against zero alerts, full scale against full scale does not
		send(16'd0, 1'b0);
		send(16'd0, 1'b0);
		send(16'hFFFF, 1'b0);
		send(16'hFFFF, 1'b0);
		send(16'd0, 1'b1);
		send(16'd1, 1'b0);
		// length zero behaves as one; count survives the write
		set_window(0);
		send(16'd5, 1'b0);
		send(16'd10, 1'b0);
		send(16'd19, 1'b0);
		// even window: threshold is the exact sum of the two middles
		set_window(2);
		send(16'd3, 1'b0);
		send(16'd4, 1'b0);
		send(16'd7, 1'b0);
		send(16'd10, 1'b0);
		send(16'd17, 1'b0);
		// odd window with duplicates, then restart on a full window
		set_window(3);
		send(16'd100, 1'b0);
		send(16'd50, 1'b0);
		send(16'd50, 1'b0);
		send(16'd99, 1'b0);
		send(16'd100, 1'b0);
		send(16'hAAAA, 1'b1);
		send(16'h5555, 1'b0);

		// back-to-back alerting beats with no idling on either side
		set_window(1);
		quiet = 1'b1;
		send(16'd0, 1'b1);
		repeat (40) send(16'd0, 1'b0);
		send(16'd5, 1'b0);
		send(16'd9, 1'b1);
		send(16'd0, 1'b0);

		// length above the maximum saturates, then the largest legal ones
		random_phase(511, MAX_WINDOW + 60);
		random_phase(MAX_WINDOW, MAX_WINDOW + 40);
		random_phase(MAX_WINDOW - 1, MAX_WINDOW + 40);
		random_phase(0, 30);
		while (random_sent < 1600) begin
			r = $urandom_range(0, 9);
			if (r < 6) len_pick = $urandom_range(1, 9);
			else if (r < 9) len_pick = $urandom_range(10, 40);
			else len_pick = $urandom_range(41, 128);
			random_phase(len_pick, len_pick + $urandom_range(10, 60));
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("%0d results checked across %0d window length writes, %0d against a full window",
			checked, settings_run, judged);
		$display("%0d alerts seen, alert count taken through restarts and length writes",
			alerts_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#3ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
